>>> rtl/core/i2cbe_pkg.sv
// Shared types, command codes and phase tables for the I2C master bit engine.
// No dependencies; every other file in rtl/core imports this package.
package i2cbe_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_SEND  = 3'd3,
		OP_RECV  = 3'd4,
		OP_SACK  = 3'd5,
		OP_RACK  = 3'd6
	} op_t;

	localparam logic [7:0] MSB_MASK = 8'h80;
	localparam int PHASE_W = 6;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       ack_value;
		logic       sda_level;
	} item_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [PHASE_W-1:0] phase;
		logic [7:0]         shift;
		logic [7:0]         rx;
		logic               ack;
		logic               scl;
		logic               sda;
	} eng_state_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_seen;
		logic       rejected;
	} result_t;

	function automatic logic [PHASE_W-1:0] seq_length(input logic [2:0] cmd);
		logic [PHASE_W-1:0] len;
		unique case (cmd)
			OP_START: len = PHASE_W'(4);
			OP_STOP:  len = PHASE_W'(3);
			OP_SEND:  len = PHASE_W'(24);
			OP_RECV:  len = PHASE_W'(32);
			OP_SACK:  len = PHASE_W'(3);
			OP_RACK:  len = PHASE_W'(4);
			default:  len = '0;
		endcase
		return len;
	endfunction

endpackage

>>> rtl/core/i2c_master_bit_engine_core.sv
// Top level of the I2C master bit engine: input register, engine state, result register.
// Depends on i2cbe_pkg and i2cbe_step.
//
// Each command word (tick, start, stop, send byte, receive byte, send ack, receive ack)
// yields exactly one result word with the open-drain SCL/SDA drive levels, busy and done
// flags, the last received byte, the last sampled ack and a rejected flag. One word is
// taken every clock cycle while cmd_stall is low; the input register loads on the taking
// edge and the result register loads from it when the result side is not stalled. A stall
// on the result side holds the result register and, while the input register holds a
// word, raises cmd_stall so that the input register holds too.
module i2c_master_bit_engine_core import i2cbe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [2:0] opcode,
	input  logic [7:0] tx_byte,
	input  logic       ack_value,
	input  logic       sda_level,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       scl_drive,
	output logic       sda_drive,
	output logic       busy_res,
	output logic       done_res,
	output logic [7:0] rx_byte,
	output logic       ack_seen,
	output logic       rejected
);

	logic       valid_s1;
	item_t      item_s1;
	eng_state_t state_q;
	eng_state_t state_nxt;
	result_t    res_nxt;
	result_t    res_q;
	logic       res_valid_q;
	logic       advance;
	logic       accept;

	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;
	assign accept    = cmd_valid && !cmd_stall;

	i2cbe_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{opcode: opcode, tx_byte: tx_byte,
				ack_value: ack_value, sda_level: sda_level};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{cmd: OP_TICK, phase: '0, shift: 8'h00, rx: 8'h00,
				ack: 1'b1, scl: 1'b1, sda: 1'b1};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign scl_drive = res_q.scl_drive;
	assign sda_drive = res_q.sda_drive;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign rx_byte   = res_q.rx_byte;
	assign ack_seen  = res_q.ack_seen;
	assign rejected  = res_q.rejected;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.done_res |-> !res_q.busy_res)
		else $error("done reported while still busy");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.rejected |-> res_q.busy_res)
		else $error("command rejected while idle");

	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cmd == OP_TICK |-> state_q.phase == '0)
		else $error("phase count not cleared while idle");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cmd != OP_TICK |-> state_q.phase < seq_length(state_q.cmd))
		else $error("phase count beyond command length");

	a_busy_track: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_q.busy_res == (state_q.cmd != OP_TICK))
		else $error("busy flag disagrees with engine state");

endmodule

>>> rtl/core/i2cbe_step.sv
// Next-state and result logic for one command word of the I2C bit engine.
// Depends on i2cbe_pkg; purely combinational, registered by the top level.
module i2cbe_step import i2cbe_pkg::*; (
	input  item_t      item,
	input  eng_state_t cur,
	output eng_state_t nxt,
	output result_t    res
);

	logic [12:0]        prod3;
	logic [4:0]         div3;
	logic [PHASE_W-1:0] sub3_full;
	logic [1:0]         sub3;
	logic [2:0]         idx3;
	logic [1:0]         sub4;
	logic [2:0]         idx4;
	logic [PHASE_W-1:0] len;
	logic [PHASE_W-1:0] ph_inc;
	logic               done;
	logic               rej;

	assign prod3     = {7'd0, cur.phase} * 13'd43;
	assign div3      = prod3[11:7];
	assign sub3_full = cur.phase - PHASE_W'({div3, 1'b0}) - PHASE_W'(div3);
	assign sub3      = sub3_full[1:0];
	assign idx3      = div3[2:0];
	assign sub4      = cur.phase[1:0];
	assign idx4      = cur.phase[4:2];
	assign len       = seq_length(cur.cmd);
	assign ph_inc    = cur.phase + PHASE_W'(1);

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		rej  = 1'b0;
		if (item.opcode == OP_TICK) begin
			if (cur.cmd != OP_TICK) begin
				if (cur.phase < len) begin
					unique case (cur.cmd)
						OP_START: begin
							unique case (cur.phase[1:0])
								2'd0: nxt.sda = 1'b1;
								2'd1: nxt.scl = 1'b1;
								2'd2: nxt.sda = 1'b0;
								default: nxt.scl = 1'b0;
							endcase
						end
						OP_STOP: begin
							priority if (cur.phase == '0) nxt.sda = 1'b0;
							else if (cur.phase == PHASE_W'(1)) nxt.scl = 1'b1;
							else nxt.sda = 1'b1;
						end
						OP_SEND, OP_SACK: begin
							priority if (sub3 == 2'd0) nxt.sda = cur.shift[3'd7 - idx3];
							else if (sub3 == 2'd1) nxt.scl = 1'b1;
							else nxt.scl = 1'b0;
						end
						OP_RECV, OP_RACK: begin
							unique case (sub4)
								2'd0: nxt.sda = 1'b1;
								2'd1: nxt.scl = 1'b1;
								2'd2: begin
									if (cur.cmd == OP_RECV) begin
										if (item.sda_level)
											nxt.shift = cur.shift | (MSB_MASK >> idx4);
									end else begin
										nxt.ack = item.sda_level;
									end
								end
								default: nxt.scl = 1'b0;
							endcase
						end
						default: ;
					endcase
				end
				if (ph_inc >= len) begin
					if (cur.cmd == OP_RECV)
						nxt.rx = nxt.shift;
					nxt.cmd   = OP_TICK;
					nxt.phase = '0;
					done      = 1'b1;
				end else begin
					nxt.phase = ph_inc;
				end
			end
		end else if (item.opcode <= OP_RACK) begin
			if (cur.cmd != OP_TICK) begin
				rej = 1'b1;
			end else begin
				nxt.cmd   = item.opcode;
				nxt.phase = '0;
				priority if (item.opcode == OP_SEND) nxt.shift = item.tx_byte;
				else if (item.opcode == OP_SACK) nxt.shift = item.ack_value ? MSB_MASK : 8'h00;
				else nxt.shift = 8'h00;
			end
		end
	end

	always_comb begin
		res.scl_drive = nxt.scl;
		res.sda_drive = nxt.sda;
		res.busy_res  = (nxt.cmd != OP_TICK);
		res.done_res  = done;
		res.rx_byte   = nxt.rx;
		res.ack_seen  = nxt.ack;
		res.rejected  = rej;
	end

endmodule

>>> tb/i2c_master_bit_engine_core_tb.sv
// Testbench for i2c_master_bit_engine_core: directed table, then random command sequences.
// Each result is checked against its typed row or a line-level engine model in this file.
// Depends on i2cbe_pkg and the core RTL.
module i2c_master_bit_engine_core_tb;
	import i2cbe_pkg::*;

	localparam int RUN_WORDS   = 1850;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [2:0] op;
		logic [7:0] txb;
		logic       ackv;
		logic       sda;
		int         reps;
		bit         typed;
		result_t    want;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_stall;
	logic [2:0] opcode;
	logic [7:0] tx_byte;
	logic       ack_value;
	logic       sda_level;
	logic       res_valid;
	logic       res_stall;
	logic       scl_drive;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_seen;
	logic       rejected;

	op_t        eng_cmd   = OP_TICK;
	logic [5:0] eng_phase = '0;
	logic [7:0] eng_shift = '0;
	logic [7:0] eng_rx    = '0;
	logic       eng_ack   = 1'b1;
	logic       eng_scl   = 1'b1;
	logic       eng_sda   = 1'b1;

	result_t    pin_status_q[$];
	dir_row_t   dir_rows[$];
	int         errors = 0;
	int         words_taken = 0;
	int         results_checked = 0;
	int         rejects_seen = 0;
	int         dones_seen = 0;
	int         cycles = 0;
	int         send_gap_pct = 9;
	int         res_hold_pct = 68;

	i2c_master_bit_engine_core uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int phase_total(op_t cmd);
		case (cmd)
			OP_START: return 4;
			OP_STOP:  return 3;
			OP_SEND:  return 24;
			OP_RECV:  return 32;
			OP_SACK:  return 3;
			OP_RACK:  return 4;
			default:  return 0;
		endcase
	endfunction

	function automatic result_t engine_step(logic [2:0] op, logic [7:0] txb, logic ackv,
			logic sda_in);
		result_t    r;
		int         len;
		logic [2:0] bit_i;
		r = '0;
		len = phase_total(eng_cmd);
		if (op == OP_TICK) begin
			if (eng_cmd != OP_TICK) begin
				if (eng_phase < len) begin
					case (eng_cmd)
						OP_START: begin
							case (eng_phase)
								6'd0: eng_sda = 1'b1;
								6'd1: eng_scl = 1'b1;
								6'd2: eng_sda = 1'b0;
								default: eng_scl = 1'b0;
							endcase
						end
						OP_STOP: begin
							case (eng_phase)
								6'd0: eng_sda = 1'b0;
								6'd1: eng_scl = 1'b1;
								default: eng_sda = 1'b1;
							endcase
						end
						OP_SEND, OP_SACK: begin
							bit_i = 3'(eng_phase / 3);
							case (eng_phase % 3)
								6'd0: eng_sda = eng_shift[7 - bit_i];
								6'd1: eng_scl = 1'b1;
								default: eng_scl = 1'b0;
							endcase
						end
						OP_RECV, OP_RACK: begin
							bit_i = eng_phase[4:2];
							case (eng_phase[1:0])
								2'd0: eng_sda = 1'b1;
								2'd1: eng_scl = 1'b1;
								2'd2: begin
									if (eng_cmd == OP_RECV) begin
										if (sda_in)
											eng_shift[7 - bit_i] = 1'b1;
									end else begin
										eng_ack = sda_in;
									end
								end
								default: eng_scl = 1'b0;
							endcase
						end
						default: ;
					endcase
				end
				eng_phase = eng_phase + 6'd1;
				if (eng_phase >= len) begin
					if (eng_cmd == OP_RECV)
						eng_rx = eng_shift;
					eng_cmd = OP_TICK;
					eng_phase = '0;
					r.done_res = 1'b1;
				end
			end
		end else if (op <= OP_RACK) begin
			if (eng_cmd != OP_TICK) begin
				r.rejected = 1'b1;
			end else begin
				eng_cmd = op_t'(op);
				eng_phase = '0;
				if (op == OP_SEND)
					eng_shift = txb;
				else if (op == OP_SACK)
					eng_shift = {ackv, 7'b0};
				else
					eng_shift = '0;
			end
		end
		r.scl_drive = eng_scl;
		r.sda_drive = eng_sda;
		r.busy_res  = (eng_cmd != OP_TICK);
		r.rx_byte   = eng_rx;
		r.ack_seen  = eng_ack;
		return r;
	endfunction

	function automatic dir_row_t mk_row(logic [2:0] op, logic [7:0] txb, logic ackv,
			logic sda, int reps, bit typed, result_t want);
		dir_row_t d;
		d.op = op;
		d.txb = txb;
		d.ackv = ackv;
		d.sda = sda;
		d.reps = reps;
		d.typed = typed;
		d.want = want;
		return d;
	endfunction

	task automatic put_word(logic [2:0] op, logic [7:0] txb, logic ackv, logic sda,
			bit typed, result_t want);
		result_t predicted;
		if (words_taken < RUN_WORDS / 3) begin
			send_gap_pct = 9;
			res_hold_pct = 68;
		end else if (words_taken < 2 * RUN_WORDS / 3) begin
			send_gap_pct = 68;
			res_hold_pct = 9;
		end else begin
			send_gap_pct = 0;
			res_hold_pct = 0;
		end
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		tx_byte <= txb;
		ack_value <= ackv;
		sda_level <= sda;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		words_taken++;
		predicted = engine_step(op, txb, ackv, sda);
		if (predicted.rejected)
			rejects_seen++;
		if (predicted.done_res)
			dones_seen++;
		pin_status_q.push_back(typed ? want : predicted);
	endtask

	task automatic field_check(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pin_status_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				want = pin_status_q.pop_front();
				results_checked++;
				field_check("scl_drive", want.scl_drive, scl_drive);
				field_check("sda_drive", want.sda_drive, sda_drive);
				field_check("busy_res", want.busy_res, busy_res);
				field_check("done_res", want.done_res, done_res);
				field_check("rx_byte", want.rx_byte, rx_byte);
				field_check("ack_seen", want.ack_seen, ack_seen);
				field_check("rejected", want.rejected, rejected);
			end
		end
		res_stall <= ($urandom_range(99) < res_hold_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		dir_row_t   d;
		logic [2:0] op;
		logic [7:0] txb;
		int         pick;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid <= 1'b0;
		opcode <= OP_TICK;
		tx_byte <= '0;
		ack_value <= 1'b0;
		sda_level <= 1'b0;
		res_stall <= 1'b0;

		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 1, 1,
			result_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}));
		dir_rows.push_back(mk_row(3'd7, 8'hff, 1'b1, 1'b1, 1, 1,
			result_t'{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0}));
		dir_rows.push_back(mk_row(OP_START, 8'h00, 1'b0, 1'b0, 1, 1,
			result_t'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0}));
		dir_rows.push_back(mk_row(OP_STOP, 8'h00, 1'b0, 1'b0, 1, 1,
			result_t'{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b1}));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 4, 0, '0));
		dir_rows.push_back(mk_row(OP_SEND, 8'ha5, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 24, 0, '0));
		dir_rows.push_back(mk_row(OP_RECV, 8'h00, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 10, 0, '0));
		dir_rows.push_back(mk_row(OP_SEND, 8'h3c, 1'b1, 1'b1, 1, 0, '0));
		dir_rows.push_back(mk_row(3'd7, 8'h00, 1'b0, 1'b1, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 22, 0, '0));
		dir_rows.push_back(mk_row(OP_SACK, 8'h00, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 3, 0, '0));
		dir_rows.push_back(mk_row(OP_SACK, 8'h00, 1'b1, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 3, 0, '0));
		dir_rows.push_back(mk_row(OP_RACK, 8'h00, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 4, 0, '0));
		dir_rows.push_back(mk_row(OP_RACK, 8'h00, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b1, 4, 0, '0));
		dir_rows.push_back(mk_row(OP_SEND, 8'h00, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'hff, 1'b1, 1'b1, 24, 0, '0));
		dir_rows.push_back(mk_row(OP_SEND, 8'hff, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 24, 0, '0));
		dir_rows.push_back(mk_row(OP_RECV, 8'hff, 1'b1, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 32, 0, '0));
		dir_rows.push_back(mk_row(OP_STOP, 8'h00, 1'b0, 1'b0, 1, 0, '0));
		dir_rows.push_back(mk_row(OP_TICK, 8'h00, 1'b0, 1'b0, 3, 0, '0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			d = dir_rows[i];
			repeat (d.reps)
				put_word(d.op, d.txb, d.ackv, d.sda, d.typed, d.want);
		end

		while (words_taken < RUN_WORDS) begin
			pick = $urandom_range(99);
			if (pick < 85) begin
				op = 3'($urandom_range(6, 1));
				case ($urandom_range(9))
					0: txb = 8'h00;
					1: txb = 8'hff;
					default: txb = 8'($urandom_range(255));
				endcase
				put_word(op, txb, 1'($urandom_range(1)), 1'($urandom_range(1)), 0, '0);
				while (eng_cmd != OP_TICK) begin
					if ($urandom_range(99) < 4)
						put_word(3'($urandom_range(7, 1)), 8'($urandom_range(255)),
							1'($urandom_range(1)), 1'($urandom_range(1)), 0, '0);
					else
						put_word(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
							1'($urandom_range(1)), 0, '0);
				end
			end else begin
				put_word(3'($urandom_range(7)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'($urandom_range(1)), 0, '0);
			end
		end
		cmd_valid <= 1'b0;

		while (pin_status_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d command words sent, %0d result words checked", words_taken,
			results_checked);
		$display("%0d sequences completed, %0d commands refused while busy", dones_seen,
			rejects_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/i2cbe_pkg.sv
rtl/core/i2cbe_step.sv
rtl/core/i2c_master_bit_engine_core.sv
tb/i2c_master_bit_engine_core_tb.sv
